FILE: src/jsu_pkg.sv
// shared types, constants and helper functions for the json string unescaper
// no dependencies; imported by every module of the block
`default_nettype none
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;

  localparam logic [15:0] UTF8_1B_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_2B_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
  localparam logic [7:0]  UTF8_CONT     = 8'h80;
  localparam logic [5:0]  UTF8_CONT_MASK = 6'h3F;

  localparam logic [2:0] HEX_DIGITS = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_ESCAPE = 2'd2,
    MODE_HEX    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_NOSTR  = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_t;

  // one request from the front: up to three data bytes, then an optional marker
  typedef struct packed {
    logic [1:0]      n_data;
    logic [2:0][7:0] data;
    logic            has_tail;
    kind_t           tail_kind;
  } job_t;

  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
  } utf8_t;

  function automatic logic [3:0] hex_value(input logic [7:0] h);
    logic [3:0] v;
    v = 4'd0;
    if (h >= 8'h30 && h <= 8'h39) v = 4'(h - 8'h30);
    else if (h >= 8'h61 && h <= 8'h66) v = 4'(h - 8'h57);
    else if (h >= 8'h41 && h <= 8'h46) v = 4'(h - 8'h37);
    return v;
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] e);
    logic [7:0] r;
    r = e;
    unique case (e)
      CH_N:    r = 8'h0A;
      CH_T:    r = 8'h09;
      CH_R:    r = 8'h0D;
      CH_B:    r = 8'h08;
      CH_F:    r = 8'h0C;
      default: r = e;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] v);
    utf8_t u;
    u = '0;
    if (v < UTF8_1B_LIMIT) begin
      u.n        = 2'd1;
      u.bytes[0] = v[7:0];
    end else if (v < UTF8_2B_LIMIT) begin
      u.n        = 2'd2;
      u.bytes[0] = UTF8_LEAD2 | {3'b000, v[10:6]};
      u.bytes[1] = UTF8_CONT | {2'b00, v[5:0] & UTF8_CONT_MASK};
    end else begin
      u.n        = 2'd3;
      u.bytes[0] = UTF8_LEAD3 | {4'b0000, v[15:12]};
      u.bytes[1] = UTF8_CONT | {2'b00, v[11:6] & UTF8_CONT_MASK};
      u.bytes[2] = UTF8_CONT | {2'b00, v[5:0] & UTF8_CONT_MASK};
    end
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: src/jsu_front.sv
// front end: scan state machine, classifies each raw byte into a request
// depends on jsu_pkg
`default_nettype none
module jsu_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc_en,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_end_of_buffer,
  output jsu_pkg::job_t     job,
  output logic              job_emit
);
  import jsu_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;

  logic [15:0] acc_shift;
  logic [2:0]  cnt_inc;
  logic        ended;
  utf8_t       u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= 3'd0;
      acc_r  <= 16'd0;
    end else if (acc_en) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_comb begin
    acc_shift = {acc_r[11:0], hex_value(in_byte)};
    cnt_inc   = cnt_r + 3'd1;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    job       = '0;
    ended     = 1'b0;
    u         = '0;
    unique case (mode_r)
      MODE_IDLE: begin
        if (in_byte == CH_QUOTE) begin
          mode_nxt = MODE_STRING;
        end else begin
          job.has_tail  = 1'b1;
          job.tail_kind = KIND_NOSTR;
          ended         = 1'b1;
          mode_nxt      = MODE_IDLE;
          cnt_nxt       = 3'd0;
          acc_nxt       = 16'd0;
        end
      end
      MODE_STRING: begin
        if (in_byte == CH_QUOTE) begin
          job.has_tail  = 1'b1;
          job.tail_kind = KIND_CLOSED;
          ended         = 1'b1;
          mode_nxt      = MODE_IDLE;
          cnt_nxt       = 3'd0;
          acc_nxt       = 16'd0;
        end else if (in_byte == CH_BACKSLASH) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          job.n_data  = 2'd1;
          job.data[0] = in_byte;
        end
      end
      MODE_ESCAPE: begin
        if (in_byte == CH_U) begin
          mode_nxt = MODE_HEX;
          cnt_nxt  = 3'd0;
          acc_nxt  = 16'd0;
        end else begin
          job.n_data  = 2'd1;
          job.data[0] = map_escape(in_byte);
          mode_nxt    = MODE_STRING;
        end
      end
      MODE_HEX: begin
        acc_nxt = acc_shift;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= HEX_DIGITS) begin
          u          = utf8_encode(acc_shift);
          job.n_data = u.n;
          job.data   = u.bytes;
          mode_nxt   = MODE_STRING;
          cnt_nxt    = 3'd0;
          acc_nxt    = 16'd0;
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase

    // buffer end: flush a partial \u value, then the truncated marker
    if (in_end_of_buffer && !ended) begin
      if (mode_nxt == MODE_HEX) begin
        u          = utf8_encode(acc_nxt);
        job.n_data = u.n;
        job.data   = u.bytes;
      end
      job.has_tail  = 1'b1;
      job.tail_kind = KIND_TRUNC;
      mode_nxt      = MODE_IDLE;
      cnt_nxt       = 3'd0;
      acc_nxt       = 16'd0;
    end

    job_emit = (job.n_data != 2'd0) || job.has_tail;
  end

endmodule
`default_nettype wire

FILE: src/jsu_queue.sv
// small request queue between the front and back ends
// depends on jsu_pkg
`default_nettype none
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire jsu_pkg::job_t push_job,
  output logic               not_full,
  input  wire logic          pop,
  output logic               head_valid,
  output jsu_pkg::job_t      head_job
);
  import jsu_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  assign not_full   = (cnt_r != FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem[rd_ptr_r];

endmodule
`default_nettype wire

FILE: src/jsu_back.sv
// back end: expands each request into result items, one per cycle while the output is not stalled
// depends on jsu_pkg
`default_nettype none
module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire jsu_pkg::job_t head_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_kind,
  output logic               out_last
);
  import jsu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  kind_t      kind_r, kind_nxt;
  logic       last_r, last_nxt;

  logic [2:0] total;
  logic       load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload holds while the output is stalled
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
      last_r <= last_nxt;
    end
  end

  always_comb begin
    total    = {1'b0, head_job.n_data} + {2'b00, head_job.has_tail};
    load     = head_valid && (!out_valid_r || out_ready);
    last_nxt = ({1'b0, idx_r} == total - 3'd1);
    byte_nxt = 8'd0;
    kind_nxt = head_job.tail_kind;
    if (idx_r < head_job.n_data) begin
      kind_nxt = KIND_DATA;
      case (idx_r)
        2'd0:    byte_nxt = head_job.data[0];
        2'd1:    byte_nxt = head_job.data[1];
        default: byte_nxt = head_job.data[2];
      endcase
    end

    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (last_nxt) begin
        pop     = 1'b1;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

FILE: src/json_string_unescape.sv
// JSON string unescaper: takes one raw byte per cycle and delivers the
// unescaped string bytes and end markers. The front end classifies a byte
// combinationally and accepts a new byte every cycle while its request queue
// (QUEUE_DEPTH entries) has room; the back end delivers one result per cycle
// from a registered output while out_ready is high. A byte that causes at most
// one result keeps pace; a \u escape ending in two or three UTF-8 bytes, or a
// buffer end behind data, yields up to four results, which the queue absorbs.
// An accepted request is registered in the queue, then in the output register.
// depends on jsu_pkg, jsu_front, jsu_queue and jsu_back
`default_nettype none
module json_string_unescape #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_buffer,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_last
);
  import jsu_pkg::*;

  job_t job, head_job;
  logic job_emit, acc_en, not_full, head_valid, pop;

  assign in_ready = not_full;
  assign acc_en   = in_valid && in_ready;

  jsu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .acc_en           (acc_en),
    .in_byte          (in_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .job              (job),
    .job_emit         (job_emit)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (acc_en && job_emit),
    .push_job   (job),
    .not_full   (not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_kind   (out_kind),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

FILE: test/json_string_unescape_checker.sv
`timescale 1ns / 100ps
// request and result monitor for json_string_unescape: predicts the unescaped
// bytes and end markers of every accepted request and compares them in order
// depends on jsu_pkg for the mode, kind and character constants
module json_string_unescape_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_buffer,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic [1:0] out_kind,
  input  wire logic       out_last,
  output int              mismatches,
  output int              outstanding,
  output int              results_checked,
  output int              strings_closed,
  output int              strings_truncated
);
  import jsu_pkg::*;

  localparam int REPORT_CAP = 30;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  result_t     unescaped_q[$];
  mode_t       scan;
  logic [2:0]  digits_seen;
  logic [15:0] code_point;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return 4'(c - 8'h30);
    if (c inside {[8'h61:8'h66]}) return 4'(c - 8'h61 + 8'd10);
    if (c inside {[8'h41:8'h46]}) return 4'(c - 8'h41 + 8'd10);
    return 4'd0;
  endfunction

  task automatic back_to_idle();
    scan        = MODE_IDLE;
    digits_seen = 3'd0;
    code_point  = 16'd0;
  endtask

  task automatic emit(input logic [7:0] data, input kind_t kind);
    result_t r;
    r.data = data;
    r.kind = kind;
    r.last = 1'b0;
    unescaped_q.push_back(r);
  endtask

  task automatic emit_code_point(input logic [15:0] v);
    if (v < 16'h0080) begin
      emit(v[7:0], KIND_DATA);
    end else if (v < 16'h0800) begin
      emit({3'b110, v[10:6]}, KIND_DATA);
      emit({2'b10, v[5:0]}, KIND_DATA);
    end else begin
      emit({4'b1110, v[15:12]}, KIND_DATA);
      emit({2'b10, v[11:6]}, KIND_DATA);
      emit({2'b10, v[5:0]}, KIND_DATA);
    end
  endtask

  task automatic unescape_step(input logic [7:0] c, input logic eob);
    int   mark;
    logic ended;
    mark  = unescaped_q.size();
    ended = 1'b0;
    case (scan)
      MODE_IDLE: begin
        if (c == CH_QUOTE) begin
          scan = MODE_STRING;
        end else begin
          emit(8'h00, KIND_NOSTR);
          back_to_idle();
          ended = 1'b1;
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          emit(8'h00, KIND_CLOSED);
          back_to_idle();
          ended = 1'b1;
        end else if (c == CH_BACKSLASH) begin
          scan = MODE_ESCAPE;
        end else begin
          emit(c, KIND_DATA);
        end
      end
      MODE_ESCAPE: begin
        if (c == CH_U) begin
          scan        = MODE_HEX;
          digits_seen = 3'd0;
          code_point  = 16'd0;
        end else begin
          case (c)
            CH_N:    emit(8'h0A, KIND_DATA);
            CH_T:    emit(8'h09, KIND_DATA);
            CH_R:    emit(8'h0D, KIND_DATA);
            CH_B:    emit(8'h08, KIND_DATA);
            CH_F:    emit(8'h0C, KIND_DATA);
            default: emit(c, KIND_DATA);
          endcase
          scan = MODE_STRING;
        end
      end
      default: begin
        code_point  = {code_point[11:0], nibble_of(c)};
        digits_seen = digits_seen + 3'd1;
        if (digits_seen == HEX_DIGITS) begin
          emit_code_point(code_point);
          scan        = MODE_STRING;
          digits_seen = 3'd0;
          code_point  = 16'd0;
        end
      end
    endcase
    // buffer end flushes a partial \u value but drops a dangling backslash
    if (eob && !ended) begin
      if (scan == MODE_HEX) emit_code_point(code_point);
      emit(8'h00, KIND_TRUNC);
      back_to_idle();
    end
    if (unescaped_q.size() > mark) unescaped_q[unescaped_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_result();
    result_t want;
    logic    bad;
    results_checked++;
    if (unescaped_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t ns: result with nothing expected: byte %02h kind %0d last %0b",
                 $time, out_byte, out_kind, out_last);
    end else begin
      want = unescaped_q.pop_front();
      bad  = 1'b0;
      if (out_byte !== want.data) begin
        bad = 1'b1;
        if (mismatches < REPORT_CAP)
          $display("%0t ns: out_byte expected %02h, got %02h", $time, want.data, out_byte);
      end
      if (out_kind !== want.kind) begin
        bad = 1'b1;
        if (mismatches < REPORT_CAP)
          $display("%0t ns: out_kind expected %0d, got %0d", $time, want.kind, out_kind);
      end
      if (out_last !== want.last) begin
        bad = 1'b1;
        if (mismatches < REPORT_CAP)
          $display("%0t ns: out_last expected %0b, got %0b", $time, want.last, out_last);
      end
      if (bad) mismatches++;
      if (want.kind == KIND_CLOSED) strings_closed++;
      if (want.kind == KIND_TRUNC) strings_truncated++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      back_to_idle();
      unescaped_q.delete();
      mismatches        = 0;
      results_checked   = 0;
      strings_closed    = 0;
      strings_truncated = 0;
    end else begin
      if (in_valid && in_ready) unescape_step(in_byte, in_end_of_buffer);
      if (out_valid && out_ready) check_result();
    end
    outstanding = unescaped_q.size();
  end

endmodule

FILE: test/json_string_unescape_tb.sv
`timescale 1ns / 100ps
// top-level bench for json_string_unescape: drives byte buffers and a
// stalling result sink, gives the verdict from json_string_unescape_checker
// depends on jsu_pkg, json_string_unescape and json_string_unescape_checker
module json_string_unescape_tb;
  import jsu_pkg::*;

  localparam int RANDOM_BYTES   = 500;
  localparam int RX_HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT    = 200000;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte          = 8'h00;
  logic       in_end_of_buffer = 1'b0;
  logic       out_valid;
  logic       out_ready        = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  int mismatches;
  int outstanding;
  int results_checked;
  int strings_closed;
  int strings_truncated;

  int         cycle_count    = 0;
  int         bytes_sent     = 0;
  int         buffers_sent   = 0;
  bit         tx_idle_on     = 1'b1;
  bit         rx_idle_on     = 1'b1;
  bit         rx_hold_wanted = 1'b0;
  logic [7:0] buffer_bytes[$];

  always #5 clk = ~clk;

  json_string_unescape dut (.*);

  json_string_unescape_checker unescape_check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, outstanding);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eob);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_byte          <= c;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < buffer_bytes.size(); i++)
      send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
    buffers_sent++;
  endtask

  // one string literal with random plain bytes and escapes
  task automatic add_string();
    int         pieces;
    int         sel;
    int         span;
    int         v;
    logic [7:0] c;
    buffer_bytes.push_back(CH_QUOTE);
    pieces = $urandom_range(0, 10);
    repeat (pieces) begin
      sel = $urandom_range(0, 7);
      if (sel < 4) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE || c == CH_BACKSLASH) c = c ^ 8'h01;
        buffer_bytes.push_back(c);
      end else if (sel < 6) begin
        case ($urandom_range(0, 9))
          0:       c = CH_N;
          1:       c = CH_T;
          2:       c = CH_R;
          3:       c = CH_B;
          4:       c = CH_F;
          5:       c = 8'h2F;
          6:       c = CH_BACKSLASH;
          7:       c = CH_QUOTE;
          default: c = 8'($urandom_range(0, 255));
        endcase
        buffer_bytes.push_back(CH_BACKSLASH);
        buffer_bytes.push_back(c);
      end else begin
        buffer_bytes.push_back(CH_BACKSLASH);
        buffer_bytes.push_back(CH_U);
        // span 0 aims at one-byte encodings, 1 at two-byte, 2 at anything
        span = $urandom_range(0, 2);
        for (int i = 0; i < 4; i++) begin
          v = $urandom_range(0, 21);
          if (v < 10) c = 8'(8'h30 + v);
          else if (v < 16) c = 8'(8'h61 + v - 10);
          else c = 8'(8'h41 + v - 16);
          if (i == 0 && span < 2) c = 8'h30;
          if (i == 1 && span == 0) c = 8'h30;
          if (i == 1 && span == 1) c = 8'(8'h30 + $urandom_range(0, 7));
          if (i == 2 && span == 0) c = 8'(8'h30 + $urandom_range(0, 7));
          if ($urandom_range(0, 11) == 0) c = 8'($urandom_range(0, 255));
          buffer_bytes.push_back(c);
        end
      end
    end
    buffer_bytes.push_back(CH_QUOTE);
  endtask

  // result sink: random stalls, stretches without stalls, one long hold-off
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_wanted) begin
        rx_hold_wanted = 1'b0;
        repeat (RX_HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      if ($urandom_range(0, 39) == 0) rx_idle_on = !rx_idle_on;
      stall = rx_idle_on ? $urandom_range(0, 7) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    int target;
    int cut;
    bit hold_done;
    hold_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes in idle, open at buffer end, one mapped and one
    // unmapped escape, \u of two and three bytes, non-hex digits, dangling backslash
    send_byte(8'h00, 1'b0);
    buffer_bytes = '{8'hFF};
    send_buffer();
    buffer_bytes = '{CH_QUOTE};
    send_buffer();
    buffer_bytes = '{CH_QUOTE, 8'hFF, CH_BACKSLASH, CH_N, CH_BACKSLASH, 8'h71, CH_QUOTE};
    send_buffer();
    buffer_bytes = '{CH_QUOTE, CH_BACKSLASH, CH_U, 8'h30, 8'h37, 8'h66, 8'h46,
                     CH_BACKSLASH, CH_U, 8'h37, 8'h46, 8'h46, 8'h46};
    send_buffer();
    buffer_bytes = '{CH_QUOTE, CH_BACKSLASH, CH_U, CH_QUOTE, CH_BACKSLASH};
    send_buffer();
    buffer_bytes = '{CH_QUOTE, CH_BACKSLASH};
    send_buffer();

    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      buffer_bytes.delete();
      tx_idle_on = $urandom_range(0, 3) != 0;
      if (!hold_done && bytes_sent > target - 300) begin
        hold_done      = 1'b1;
        rx_hold_wanted = 1'b1;
        tx_idle_on     = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        buffer_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          add_string();
          if ($urandom_range(0, 4) == 0) buffer_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      // cut some buffers anywhere, mid-escape included
      if ($urandom_range(0, 9) < 3) begin
        cut = $urandom_range(1, buffer_bytes.size());
        while (buffer_bytes.size() > cut) void'(buffer_bytes.pop_back());
      end
      send_buffer();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d buffers, with random gaps and one long sink hold-off",
             bytes_sent, buffers_sent);
    $display("checked %0d results: %0d strings closed, %0d cut at buffer end, %0d mismatches",
             results_checked, strings_closed, strings_truncated, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape.sv
test/json_string_unescape_checker.sv
test/json_string_unescape_tb.sv
